// ----- hdl/sgcs_pkg.sv -----
// sgcs_pkg: shared types and constants of the staggered-grid curl stencil
// used by the result queue, the top level and the bench; no dependencies
`default_nettype none

package sgcs_pkg;

    localparam int SIZE_W   = 7;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = 34;
    localparam int FIFO_DEPTH = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    typedef logic signed [31:0] t_q16;

    typedef struct packed {
        t_q16 x;
        t_q16 y;
        t_q16 z;
    } t_vec;

    // one entry of the vorticity store: index 0 and 1 are the two plane parities
    typedef t_vec [1:0] t_vec_pair;

    typedef struct packed {
        logic edge_valid;
        t_vec edge_v;
        logic center_valid;
        t_vec center_v;
    } t_res;

    function automatic t_q16 sat32(input logic signed [TERM_W:0] v);
        if (&v[TERM_W:31] || ~|v[TERM_W:31]) begin
            return v[31:0];
        end
        return v[TERM_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sgcs_ifs.sv -----
// sgcs_in_if / sgcs_out_if: valid-ready channels of the curl stencil
// point beats in, result beats out; no dependencies
`default_nettype none

interface sgcs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] vel_u;
    logic [31:0] vel_v;
    logic [31:0] vel_w;
    logic [31:0] inv_dx;
    logic [31:0] inv_dy;
    logic [31:0] inv_dz;
    logic        volume_start;

    modport source (output valid, vel_u, vel_v, vel_w, inv_dx, inv_dy, inv_dz,
                    volume_start, input ready);
    modport sink (input valid, vel_u, vel_v, vel_w, inv_dx, inv_dy, inv_dz,
                  volume_start, output ready);
endinterface

interface sgcs_out_if;
    logic        valid;
    logic        ready;
    logic        edge_valid;
    logic [31:0] edge_x;
    logic [31:0] edge_y;
    logic [31:0] edge_z;
    logic        center_valid;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;

    modport source (output valid, edge_valid, edge_x, edge_y, edge_z, center_valid,
                    center_x, center_y, center_z, input ready);
    modport sink (input valid, edge_valid, edge_x, edge_y, edge_z, center_valid,
                  center_x, center_y, center_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/sgcs_fifo.sv -----
// sgcs_fifo: result queue between the stencil pipeline and the output channel
// depends on sgcs_pkg (t_res)
`default_nettype none

module sgcs_fifo
    import sgcs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_res                       i_push_data,
    input  wire logic                       i_pop,
    output t_res                            o_pop_data,
    output logic                            o_not_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_res            r_buf [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data  = r_buf[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

`default_nettype wire

// ----- hdl/staggered_grid_curl_stencil.sv -----
// staggered_grid_curl_stencil: top level of the Q16.16 curl stencil
// depends on sgcs_pkg, sgcs_ifs (sgcs_in_if, sgcs_out_if) and sgcs_fifo
//
// Grid points of a tile stream in raster order (i fastest) and the block takes one point beat
// every clock cycle while the result queue has room. Each point gives one result beat: the
// backward-difference curl at the point (edge_*) and, once i, j and k are all at least 2, the
// four-point average of the curl at (i-1, j-1, k-1) (center_*). A point goes through three
// pipeline stages and is written into an 8-entry result queue; points keep flowing while the
// queue holds results that are not yet taken, until the queue and the beats in flight fill its
// 8 slots. The figure of one point per cycle is set by the two neighbor stores, each a
// synchronous memory of MAX_NX*MAX_NY rows (rounded up to powers of two per axis) with two read
// ports and one write port: the velocity store is read at (j, i) and (j-1, i) and rewritten at
// (j, i) in the cycle the point is taken; the vorticity store holds both plane parities per row
// and is written from stage 3, so a short history of recent writes is forwarded onto its read
// data. Neither store is cleared after reset and there is no clearing pass; an entry reads as
// whatever it holds until a point of the tile writes it. Grid sizes are set through the APB
// port (grid_size_x at 0x0, grid_size_y at 0x4, grid_size_z at 0x8), are clamped to
// 3..MAX_N*, and may only be changed while no point is in flight. volume_start restarts the
// position counters at (0,0,0); after the last point of a tile they wrap on their own.
`default_nettype none

module staggered_grid_curl_stencil
    import sgcs_pkg::*;
#(
    parameter int MAX_NX = 64,
    parameter int MAX_NY = 64,
    parameter int MAX_NZ = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    sgcs_in_if.sink                 i_pnt,
    sgcs_out_if.source              o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int XW    = $clog2(MAX_NX);
    localparam int YW    = $clog2(MAX_NY);
    localparam int ZW    = $clog2(MAX_NZ);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CNTW  = $clog2(FIFO_DEPTH + 1);
    localparam int OCCW  = $clog2(FIFO_DEPTH + 4);

    // record of one vorticity store write, kept for forwarding
    typedef struct packed {
        logic          vld;
        logic [AW-1:0] addr;
        logic          par;
        t_vec          e;
    } t_wrec;

    // ---------------------------------------------------------------- config port
    logic [SIZE_W-1:0] r_size_x;
    logic [SIZE_W-1:0] r_size_y;
    logic [SIZE_W-1:0] r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SIZE_X: r_size_x <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y: r_size_y <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z: r_size_z <= pwdata[SIZE_W-1:0];
                default:    r_size_x <= r_size_x;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = APB_DW'(r_size_x);
            REG_SIZE_Y: prdata = APB_DW'(r_size_y);
            REG_SIZE_Z: prdata = APB_DW'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // clamped sizes, one bit wider than the index so MAX_N* itself fits
    logic [XW:0] w_nx;
    logic [YW:0] w_ny;
    logic [ZW:0] w_nz;

    always_comb begin
        if (r_size_x < SIZE_MIN)            w_nx = (XW+1)'(SIZE_MIN);
        else if (int'(r_size_x) > MAX_NX)   w_nx = (XW+1)'(MAX_NX);
        else                                w_nx = (XW+1)'(r_size_x);
        if (r_size_y < SIZE_MIN)            w_ny = (YW+1)'(SIZE_MIN);
        else if (int'(r_size_y) > MAX_NY)   w_ny = (YW+1)'(MAX_NY);
        else                                w_ny = (YW+1)'(r_size_y);
        if (r_size_z < SIZE_MIN)            w_nz = (ZW+1)'(SIZE_MIN);
        else if (int'(r_size_z) > MAX_NZ)   w_nz = (ZW+1)'(MAX_NZ);
        else                                w_nz = (ZW+1)'(r_size_z);
    end

    // ---------------------------------------------------------------- input side
    logic            w_ready;
    logic            w_acc;
    t_vec            w_in_vel;
    logic [XW-1:0]   r_pos_i, n_pos_i, w_i;
    logic [YW-1:0]   r_pos_j, n_pos_j, w_j;
    logic [ZW-1:0]   r_pos_k, n_pos_k, w_k;
    logic [AW-1:0]   w_addr_here;
    logic [AW-1:0]   w_addr_up;
    logic [XW:0]     w_i_inc;
    logic [YW:0]     w_j_inc;
    logic [ZW:0]     w_k_inc;

    assign w_acc    = i_pnt.valid && w_ready;
    assign w_in_vel = '{x: i_pnt.vel_u, y: i_pnt.vel_v, z: i_pnt.vel_w};

    // volume_start forces the point to the origin
    assign w_i = i_pnt.volume_start ? '0 : r_pos_i;
    assign w_j = i_pnt.volume_start ? '0 : r_pos_j;
    assign w_k = i_pnt.volume_start ? '0 : r_pos_k;

    assign w_addr_here = {w_j, w_i};
    assign w_addr_up   = {w_j - 1'b1, w_i};

    assign w_i_inc = {1'b0, w_i} + 1'b1;
    assign w_j_inc = {1'b0, w_j} + 1'b1;
    assign w_k_inc = {1'b0, w_k} + 1'b1;

    // raster advance, each counter wraps at its clamped size
    always_comb begin
        n_pos_i = w_i_inc[XW-1:0];
        n_pos_j = w_j;
        n_pos_k = w_k;
        if (w_i_inc >= w_nx) begin
            n_pos_i = '0;
            n_pos_j = w_j_inc[YW-1:0];
            if (w_j_inc >= w_ny) begin
                n_pos_j = '0;
                n_pos_k = w_k_inc[ZW-1:0];
                if (w_k_inc >= w_nz) begin
                    n_pos_k = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_i <= '0;
            r_pos_j <= '0;
            r_pos_k <= '0;
        end else if (w_acc) begin
            r_pos_i <= n_pos_i;
            r_pos_j <= n_pos_j;
            r_pos_k <= n_pos_k;
        end
    end

    // ---------------------------------------------------------------- velocity store
    // read before write, so a point sees its own row entry as it was
    t_vec r_vel_mem [DEPTH];
    t_vec r_vel_rd_here;
    t_vec r_vel_rd_up;

    always_ff @(posedge i_clk) begin
        r_vel_rd_here <= r_vel_mem[w_addr_here];
        r_vel_rd_up   <= r_vel_mem[w_addr_up];
        if (w_acc) begin
            r_vel_mem[w_addr_here] <= w_in_vel;
        end
    end

    // the i-1 neighbor is always the point just before
    t_vec r_prev_vel;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prev_vel <= w_in_vel;
        end
    end

    // ---------------------------------------------------------------- vorticity store
    t_vec_pair r_vort_mem [DEPTH];
    t_vec_pair r_vort_rd_here;
    t_vec_pair r_vort_rd_up;
    logic      r_s3_vld;
    logic      r_s3_par;
    logic [AW-1:0] r_s3_addr_here;
    t_vec      w_e;

    always_ff @(posedge i_clk) begin
        r_vort_rd_here <= r_vort_mem[w_addr_here];
        r_vort_rd_up   <= r_vort_mem[w_addr_up];
        if (r_s3_vld) begin
            r_vort_mem[r_s3_addr_here][r_s3_par] <= w_e;
        end
    end

    // ---------------------------------------------------------------- stage 1: differences
    logic                     r_s1_vld;
    logic                     r_s1_eok;
    logic                     r_s1_cok;
    logic                     r_s1_par;
    logic [AW-1:0]            r_s1_addr_here;
    logic [AW-1:0]            r_s1_addr_up;
    t_vec                     r_s1_vel;
    t_vec                     r_s1_prev;
    logic [31:0]              r_s1_inv_x;
    logic [31:0]              r_s1_inv_y;
    logic [31:0]              r_s1_inv_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_eok       <= (w_i != '0) && (w_j != '0) && (w_k != '0);
            r_s1_cok       <= (w_i > XW'(1)) && (w_j > YW'(1)) && (w_k > ZW'(1));
            r_s1_par       <= w_k[0];
            r_s1_addr_here <= w_addr_here;
            r_s1_addr_up   <= w_addr_up;
            r_s1_vel       <= w_in_vel;
            r_s1_prev      <= r_prev_vel;
            r_s1_inv_x     <= i_pnt.inv_dx;
            r_s1_inv_y     <= i_pnt.inv_dy;
            r_s1_inv_z     <= i_pnt.inv_dz;
        end
    end

    // lanes: 0,1 form curl x; 2,3 curl y; 4,5 curl z
    logic signed [DIFF_W-1:0] w_diff [6];
    logic [31:0]              w_inv  [6];

    always_comb begin
        w_diff[0] = DIFF_W'(r_s1_vel.z) - DIFF_W'(r_vel_rd_up.z);
        w_diff[1] = DIFF_W'(r_s1_vel.y) - DIFF_W'(r_vel_rd_here.y);
        w_diff[2] = DIFF_W'(r_s1_vel.x) - DIFF_W'(r_vel_rd_here.x);
        w_diff[3] = DIFF_W'(r_s1_vel.z) - DIFF_W'(r_s1_prev.z);
        w_diff[4] = DIFF_W'(r_s1_vel.y) - DIFF_W'(r_s1_prev.y);
        w_diff[5] = DIFF_W'(r_s1_vel.x) - DIFF_W'(r_vel_rd_up.x);
        w_inv[0]  = r_s1_inv_y;
        w_inv[1]  = r_s1_inv_z;
        w_inv[2]  = r_s1_inv_z;
        w_inv[3]  = r_s1_inv_x;
        w_inv[4]  = r_s1_inv_x;
        w_inv[5]  = r_s1_inv_y;
    end

    // ---------------------------------------------------------------- stage 2: products
    logic                     r_s2_vld;
    logic                     r_s2_eok;
    logic                     r_s2_cok;
    logic                     r_s2_par;
    logic [AW-1:0]            r_s2_addr_here;
    logic [AW-1:0]            r_s2_addr_up;
    t_vec                     r_s2_hp;
    t_vec                     r_s2_up_p;
    t_vec                     r_s2_up_c;
    logic signed [DIFF_W-1:0] r_s2_diff [6];
    logic [31:0]              r_s2_inv  [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // raw store data split by plane: p is the current plane, !p the previous one
    always_ff @(posedge i_clk) begin
        r_s2_eok       <= r_s1_eok;
        r_s2_cok       <= r_s1_cok;
        r_s2_par       <= r_s1_par;
        r_s2_addr_here <= r_s1_addr_here;
        r_s2_addr_up   <= r_s1_addr_up;
        r_s2_hp        <= r_vort_rd_here[~r_s1_par];
        r_s2_up_p      <= r_vort_rd_up[~r_s1_par];
        r_s2_up_c      <= r_vort_rd_up[r_s1_par];
        r_s2_diff      <= w_diff;
        r_s2_inv       <= w_inv;
    end

    logic signed [DIFF_W-1:0] w_inv_s  [6];
    logic signed [PROD_W-1:0] w_prod   [6];

    always_comb begin
        for (int n = 0; n < 6; n++) begin
            w_inv_s[n] = {1'b0, r_s2_inv[n]};
            w_prod[n]  = r_s2_diff[n] * w_inv_s[n];
        end
    end

    // ---------------------------------------------------------------- stage 3: curl, average
    logic                     r_s3_eok;
    logic                     r_s3_cok;
    logic [AW-1:0]            r_s3_addr_up;
    t_vec                     r_s3_hp;
    t_vec                     r_s3_up_p;
    t_vec                     r_s3_up_c;
    logic signed [TERM_W-1:0] r_s3_term [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    // floor shift of the exact product
    always_ff @(posedge i_clk) begin
        r_s3_eok       <= r_s2_eok;
        r_s3_cok       <= r_s2_cok;
        r_s3_par       <= r_s2_par;
        r_s3_addr_here <= r_s2_addr_here;
        r_s3_addr_up   <= r_s2_addr_up;
        r_s3_hp        <= r_s2_hp;
        r_s3_up_p      <= r_s2_up_p;
        r_s3_up_c      <= r_s2_up_c;
        for (int n = 0; n < 6; n++) begin
            r_s3_term[n] <= w_prod[n][PROD_W-1:FRAC_W];
        end
    end

    logic signed [TERM_W:0] w_comp [3];

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            w_comp[n] = {r_s3_term[2*n][TERM_W-1], r_s3_term[2*n]}
                      - {r_s3_term[2*n+1][TERM_W-1], r_s3_term[2*n+1]};
        end
        if (r_s3_eok) begin
            w_e = '{x: sat32(w_comp[0]), y: sat32(w_comp[1]), z: sat32(w_comp[2])};
        end else begin
            w_e = '0;
        end
    end

    // recent writes missed by this point's store read, kept in a three-entry history
    t_wrec r_hist [3];
    t_wrec w_wrec;
    t_vec  w_hp;
    t_vec  w_up_p;
    t_vec  w_up_c;

    assign w_wrec = '{vld: r_s3_vld, addr: r_s3_addr_here, par: r_s3_par, e: w_e};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 3; n++) begin
                r_hist[n].vld <= 1'b0;
            end
        end else begin
            r_hist[0] <= w_wrec;
            r_hist[1] <= r_hist[0];
            r_hist[2] <= r_hist[1];
        end
    end

    // oldest first so the newest write wins
    always_comb begin
        w_hp   = r_s3_hp;
        w_up_p = r_s3_up_p;
        w_up_c = r_s3_up_c;
        for (int n = 2; n >= 0; n--) begin
            if (r_hist[n].vld) begin
                if (r_hist[n].addr == r_s3_addr_here && r_hist[n].par != r_s3_par) begin
                    w_hp = r_hist[n].e;
                end
                if (r_hist[n].addr == r_s3_addr_up && r_hist[n].par != r_s3_par) begin
                    w_up_p = r_hist[n].e;
                end
                if (r_hist[n].addr == r_s3_addr_up && r_hist[n].par == r_s3_par) begin
                    w_up_c = r_hist[n].e;
                end
            end
        end
    end

    // the point before sat at (j, i-1): its reads give the (i-1) corners
    t_vec r_last_hp;
    t_vec r_last_up_p;
    t_vec r_last_up_c;
    t_vec r_last_e;

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_last_hp   <= w_hp;
            r_last_up_p <= w_up_p;
            r_last_up_c <= w_up_c;
            r_last_e    <= w_e;
        end
    end

    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;
    logic signed [SUM_W-1:0] w_sum_z;
    t_vec                    w_c;

    always_comb begin
        w_sum_x = SUM_W'(r_last_up_p.x) + SUM_W'(r_last_hp.x)
                + SUM_W'(r_last_up_c.x) + SUM_W'(r_last_e.x);
        w_sum_y = SUM_W'(r_last_up_p.y) + SUM_W'(r_last_up_c.y)
                + SUM_W'(w_up_p.y) + SUM_W'(w_up_c.y);
        w_sum_z = SUM_W'(r_last_up_p.z) + SUM_W'(r_last_hp.z)
                + SUM_W'(w_up_p.z) + SUM_W'(w_hp.z);
        if (r_s3_cok) begin
            w_c = '{x: w_sum_x[SUM_W-1:2], y: w_sum_y[SUM_W-1:2], z: w_sum_z[SUM_W-1:2]};
        end else begin
            w_c = '0;
        end
    end

    // ---------------------------------------------------------------- result queue
    t_res            w_push_data;
    t_res            w_head;
    logic            w_not_empty;
    logic [CNTW-1:0] w_fifo_cnt;
    logic [OCCW-1:0] w_occ;

    assign w_push_data = '{edge_valid: r_s3_eok, edge_v: w_e,
                           center_valid: r_s3_cok, center_v: w_c};

    sgcs_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s3_vld),
        .i_push_data (w_push_data),
        .i_pop       (o_res.valid && o_res.ready),
        .o_pop_data  (w_head),
        .o_not_empty (w_not_empty),
        .o_count     (w_fifo_cnt)
    );

    // beats in flight reserve their queue slots before they are taken
    assign w_occ   = OCCW'(w_fifo_cnt) + OCCW'(r_s1_vld) + OCCW'(r_s2_vld) + OCCW'(r_s3_vld);
    assign w_ready = (w_occ < OCCW'(FIFO_DEPTH));

    assign i_pnt.ready        = w_ready;
    assign o_res.valid        = w_not_empty;
    assign o_res.edge_valid   = w_head.edge_valid;
    assign o_res.edge_x       = w_head.edge_v.x;
    assign o_res.edge_y       = w_head.edge_v.y;
    assign o_res.edge_z       = w_head.edge_v.z;
    assign o_res.center_valid = w_head.center_valid;
    assign o_res.center_x     = w_head.center_v.x;
    assign o_res.center_y     = w_head.center_v.y;
    assign o_res.center_z     = w_head.center_v.z;

    // ---------------------------------------------------------------- checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= OCCW'(FIFO_DEPTH))
        else $error("result queue over-committed");

    a_s1_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> r_s2_vld)
        else $error("beat lost between stage 1 and stage 2");

    a_s3_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (w_fifo_cnt < CNTW'(FIFO_DEPTH)))
        else $error("push into full result queue");

    a_center_needs_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && r_s3_cok) |-> r_s3_eok)
        else $error("center result without edge result");

    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_pnt.volume_start) |=> (r_s1_vld && !r_s1_eok && !r_s1_cok))
        else $error("tile start not at origin");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for staggered_grid_curl_stencil, driving point beats,
// apb writes of the grid sizes and checking every result beat against a predictor
// depends on sgcs_pkg, sgcs_in_if, sgcs_out_if and the block itself
`default_nettype none

module tb;
    import sgcs_pkg::*;

    localparam int ROW_MAX  = 64;   // matches the block's MAX_NX default
    localparam int PLANE_SZ = 64 * 64;
    localparam int ITEMS    = 1850;

    typedef struct {
        logic [31:0] u, v, w;
        logic [31:0] idx, idy, idz;
        logic        vs;
    } t_point;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    sgcs_in_if  pnt ();
    sgcs_out_if res ();

    staggered_grid_curl_stencil DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pnt   (pnt),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor state: grid sizes as written, position counters and the
    // two neighbor stores at full tile size
    // ---------------------------------------------------------------------
    logic [SIZE_W-1:0] size_reg [3];
    int   at_i, at_j, at_k;
    t_vec vel_store  [PLANE_SZ];
    t_vec curl_store [2][PLANE_SZ];
    t_res curl_due [$];

    int  mismatches = 0;
    int  points_sent = 0;
    int  rx_hold = 0;      // one-shot long stall request for the receiver
    bit  no_gaps = 1'b0;   // stretches where neither side idles

    function automatic int eff_size(input logic [SIZE_W-1:0] r);
        if (r < 3) return 3;
        if (r > ROW_MAX) return ROW_MAX;
        return int'(r);
    endfunction

    // (a - b) * inv >> 16, exact product, floor
    function automatic logic signed [50:0] scaled_diff(input t_q16 a, input t_q16 b,
                                                       input logic [31:0] inv);
        logic signed [32:0] ea, eb, d;
        logic signed [66:0] prod;
        ea = a;
        eb = b;
        d = ea - eb;
        prod = d * $signed({1'b0, inv});
        return prod >>> FRAC_W;
    endfunction

    function automatic t_q16 clip32(input logic signed [50:0] p, input logic signed [50:0] q);
        logic signed [52:0] s, ep, eq;
        ep = p;
        eq = q;
        s = ep - eq;
        if (s > 53'sd2147483647) return 32'sh7fff_ffff;
        if (s < -53'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic t_q16 avg4(input t_q16 a, input t_q16 b, input t_q16 c, input t_q16 d);
        logic signed [33:0] s, ea, eb, ec, ed;
        ea = a; eb = b; ec = c; ed = d;
        s = ea + eb + ec + ed;
        return s >>> 2;
    endfunction

    function automatic t_res predict_curl(input t_point p);
        int   nx, ny, nz, here, a, b, d, cp, pp;
        t_vec pk, pj, pi_n, e, c;
        t_res r;
        nx = eff_size(size_reg[REG_SIZE_X]);
        ny = eff_size(size_reg[REG_SIZE_Y]);
        nz = eff_size(size_reg[REG_SIZE_Z]);
        if (p.vs) begin
            at_i = 0; at_j = 0; at_k = 0;
        end
        here = at_j * ROW_MAX + at_i;
        e = '0;
        c = '0;
        r.edge_valid   = (at_i >= 1 && at_j >= 1 && at_k >= 1);
        r.center_valid = (at_i >= 2 && at_j >= 2 && at_k >= 2);
        if (r.edge_valid) begin
            pk   = vel_store[here];
            pj   = vel_store[here - ROW_MAX];
            pi_n = vel_store[here - 1];
            e.x = clip32(scaled_diff(p.w, pj.z, p.idy), scaled_diff(p.v, pk.y, p.idz));
            e.y = clip32(scaled_diff(p.u, pk.x, p.idz), scaled_diff(p.w, pi_n.z, p.idx));
            e.z = clip32(scaled_diff(p.v, pi_n.y, p.idx), scaled_diff(p.u, pj.x, p.idy));
        end
        vel_store[here] = '{x: p.u, y: p.v, z: p.w};
        cp = at_k & 1;
        pp = cp ^ 1;
        curl_store[cp][here] = e;
        if (r.center_valid) begin
            a = here - ROW_MAX - 1;
            b = here - 1;
            d = here - ROW_MAX;
            c.x = avg4(curl_store[pp][a].x, curl_store[pp][b].x,
                       curl_store[cp][a].x, curl_store[cp][b].x);
            c.y = avg4(curl_store[pp][a].y, curl_store[cp][a].y,
                       curl_store[pp][d].y, curl_store[cp][d].y);
            c.z = avg4(curl_store[pp][a].z, curl_store[pp][b].z,
                       curl_store[pp][d].z, curl_store[pp][here].z);
        end
        r.edge_v = e;
        r.center_v = c;
        // raster advance, wrapping at each axis end
        at_i++;
        if (at_i >= nx) begin
            at_i = 0;
            at_j++;
            if (at_j >= ny) begin
                at_j = 0;
                at_k++;
                if (at_k >= nz) at_k = 0;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3ffff)
                                                 : -$urandom_range(0, 32'h3ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_inv();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2, 3, 4, 5: return $urandom_range(32'h4000, 32'h40000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_point rand_point(input logic vs);
        t_point p;
        p.u = rand_vel(); p.v = rand_vel(); p.w = rand_vel();
        p.idx = rand_inv(); p.idy = rand_inv(); p.idz = rand_inv();
        p.vs = vs;
        return p;
    endfunction

    // one point beat, predicted at the edge where it is taken
    task automatic send_point(input t_point p);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            pnt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pnt.valid        <= 1'b1;
        pnt.vel_u        <= p.u;
        pnt.vel_v        <= p.v;
        pnt.vel_w        <= p.w;
        pnt.inv_dx       <= p.idx;
        pnt.inv_dy       <= p.idy;
        pnt.inv_dz       <= p.idz;
        pnt.volume_start <= p.vs;
        @(posedge clk);
        while (!pnt.ready) @(posedge clk);
        curl_due.push_back(predict_curl(p));
        points_sent++;
    endtask

    // drop valid and wait for the pipe to empty
    task automatic drain();
        pnt.valid <= 1'b0;
        while (curl_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(input logic [1:0] reg_idx, input logic [SIZE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        size_reg[reg_idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // sizes only change with the pipe empty; the next point restarts the tile
    task automatic set_grid(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                            input logic [SIZE_W-1:0] sz);
        drain();
        write_size(REG_SIZE_X, sx);
        write_size(REG_SIZE_Y, sy);
        write_size(REG_SIZE_Z, sz);
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // smallest tile from clamped-low sizes, full-scale velocities and spacings
    task automatic test_extremes();
        t_point p;
        set_grid(7'd0, 7'd2, 7'd3);
        for (int n = 0; n < 27; n++) begin
            p.u   = (n % 2) ? 32'h7fff_ffff : 32'h8000_0000;
            p.v   = (n % 3 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            p.w   = (n % 4 < 2) ? 32'h7fff_ffff : 32'h8000_0000;
            p.idx = (n % 5 == 4) ? 32'h0 : 32'hffff_ffff;
            p.idy = (n % 7 == 6) ? 32'h0001_0000 : 32'hffff_ffff;
            p.idz = 32'hffff_ffff;
            p.vs  = (n == 0);
            send_point(p);
        end
    endtask

    // full-width rows; the receiver stalls long so the result queue backs up
    task automatic test_wide_rows();
        set_grid(7'd127, 7'd3, 7'd3);
        for (int n = 0; n < 64 * 9; n++) begin
            if (n == 100) rx_hold = 300;
            send_point(rand_point(n == 0));
        end
    endtask

    // tall planes and deep tiles, partly traversed; sender waits out the pipe
    task automatic test_tall_and_deep();
        set_grid(7'd3, 7'd64, 7'd65);
        for (int n = 0; n < 260; n++) send_point(rand_point(n == 0));
        set_grid(7'd3, 7'd3, 7'd64);
        for (int n = 0; n < 40; n++) send_point(rand_point(n == 0));
        pnt.valid <= 1'b0;
        while (curl_due.size() != 0) @(posedge clk);
        for (int n = 0; n < 40; n++) send_point(rand_point(1'b0));
    endtask

    // random small tiles, sometimes passed twice with self-wrap, rare restarts
    task automatic test_random_tiles();
        int sx, sy, sz, count;
        while (points_sent < ITEMS) begin
            sx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(3, 6);
            sy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(3, 6);
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(3, 5);
            set_grid(SIZE_W'(sx), SIZE_W'(sy), SIZE_W'(sz));
            no_gaps = ($urandom_range(0, 3) == 0);
            count = eff_size(SIZE_W'(sx)) * eff_size(SIZE_W'(sy)) * eff_size(SIZE_W'(sz))
                  * $urandom_range(1, 2);
            if (count > ITEMS - points_sent) count = ITEMS - points_sent;
            for (int n = 0; n < count; n++)
                send_point(rand_point(n == 0 || $urandom_range(0, 99) == 0));
            no_gaps = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------------
    // result side: random stalls plus the one long hold
    // ---------------------------------------------------------------------
    initial begin
        int n;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            n = draw_gap();
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
            end
            if (n > 0) begin
                res.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid) @(posedge clk);
        end
    end

    task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk) begin
        t_res want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
            if (curl_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: result beat with none pending", $realtime);
            end else begin
                want = curl_due.pop_front();
                flag_field("edge_valid", 32'(want.edge_valid), 32'(res.edge_valid));
                flag_field("edge_x", want.edge_v.x, res.edge_x);
                flag_field("edge_y", want.edge_v.y, res.edge_y);
                flag_field("edge_z", want.edge_v.z, res.edge_z);
                flag_field("center_valid", 32'(want.center_valid), 32'(res.center_valid));
                flag_field("center_x", want.center_v.x, res.center_x);
                flag_field("center_y", want.center_v.y, res.center_y);
                flag_field("center_z", want.center_v.z, res.center_z);
            end
        end
    end

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        int waited;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        pnt.valid <= 1'b0;
        pnt.vel_u <= '0; pnt.vel_v <= '0; pnt.vel_w <= '0;
        pnt.inv_dx <= '0; pnt.inv_dy <= '0; pnt.inv_dz <= '0;
        pnt.volume_start <= 1'b0;
        for (int r = 0; r < 3; r++) size_reg[r] = SIZE_RESET;
        at_i = 0; at_j = 0; at_k = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_wide_rows();
        test_tall_and_deep();
        test_random_tiles();

        pnt.valid <= 1'b0;
        waited = 0;
        while (curl_due.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && curl_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // hard limit, far above the slowest legal run
    initial begin
        #4000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
